// ===== sv/rdc_pkg.sv =====
// Shared types and constants of the radix digit converter.
// Used by every module of the block; depends on nothing.
package rdc_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int BASE_WIDTH  = 16;
  localparam int DIGIT_DEPTH = 31;

  localparam int DEPTH_W = $clog2(DIGIT_DEPTH + 1);
  localparam int IDX_W   = $clog2(DIGIT_DEPTH);
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

  localparam logic [DEPTH_W-1:0] TOP_SLOT = DEPTH_W'(DIGIT_DEPTH - 1);
  localparam logic [CNT_W-1:0]   LAST_BIT = CNT_W'(VALUE_WIDTH - 1);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [BASE_WIDTH-1:0]  base;
  } in_t;

  typedef struct packed {
    logic [BASE_WIDTH-1:0] digit;
    logic                  last;
    logic                  error;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic div_start;
    logic push;
    logic rd_req;
    logic load_digit;
    logic load_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_bad;
    logic div_done;
    logic quot_zero;
    logic full;
    logic stack_empty;
  } status_t;

endpackage

// ===== sv/rdc_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Depends on rdc_pkg for widths.
module rdc_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0]    dividend,
  input  logic [rdc_pkg::BASE_WIDTH-1:0]     divisor,
  output logic                               done,
  output logic [rdc_pkg::VALUE_WIDTH-1:0]    quotient,
  output logic [rdc_pkg::BASE_WIDTH-1:0]     remainder
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [rdc_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [rdc_pkg::VALUE_WIDTH-1:0]   quo_r, quo_nxt;
  logic [rdc_pkg::BASE_WIDTH-1:0]    rem_r, rem_nxt;
  logic [rdc_pkg::BASE_WIDTH-1:0]    div_r, div_nxt;
  logic [rdc_pkg::BASE_WIDTH:0]      shifted;
  logic [rdc_pkg::BASE_WIDTH:0]      diff;
  logic                              fits;

  assign shifted = {rem_r, quo_r[rdc_pkg::VALUE_WIDTH-1]};
  assign fits    = shifted >= {1'b0, div_r};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the shifted value needs one extra bit.
      rem_nxt = fits ? diff[rdc_pkg::BASE_WIDTH-1:0] : shifted[rdc_pkg::BASE_WIDTH-1:0];
      quo_nxt = {quo_r[rdc_pkg::VALUE_WIDTH-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rdc_pkg::LAST_BIT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== sv/rdc_datapath.sv =====
// Datapath: input registers, divider, digit stack and output register.
// Depends on rdc_pkg and rdc_divider; driven by commands from rdc_ctrl.
module rdc_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  rdc_pkg::in_t     in_data,
  input  rdc_pkg::cmd_t    cmd,
  output rdc_pkg::status_t status,
  output rdc_pkg::out_t    out_data
);

  logic [rdc_pkg::VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [rdc_pkg::BASE_WIDTH-1:0]  base_r, base_nxt;
  logic [rdc_pkg::DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [rdc_pkg::DEPTH_W-1:0]     depth_m1;
  logic [rdc_pkg::BASE_WIDTH-1:0]  rd_data_r;
  rdc_pkg::out_t                   out_r, out_nxt;

  logic [rdc_pkg::BASE_WIDTH-1:0]  stack_mem [rdc_pkg::DIGIT_DEPTH];

  logic                            div_done;
  logic [rdc_pkg::VALUE_WIDTH-1:0] div_quot;
  logic [rdc_pkg::BASE_WIDTH-1:0]  div_rem;

  rdc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (quot_r),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign depth_m1 = depth_r - 1'b1;

  always_comb begin
    quot_nxt  = quot_r;
    base_nxt  = base_r;
    depth_nxt = depth_r;
    out_nxt   = out_r;
    if (cmd.load_in) begin
      quot_nxt  = in_data.value;
      base_nxt  = in_data.base;
      depth_nxt = '0;
    end
    if (cmd.push) begin
      quot_nxt  = div_quot;
      depth_nxt = depth_r + 1'b1;
    end
    if (cmd.rd_req) begin
      depth_nxt = depth_m1;
    end
    if (cmd.load_digit) begin
      out_nxt.digit = rd_data_r;
      out_nxt.last  = (depth_r == '0);
      out_nxt.error = 1'b0;
    end
    if (cmd.load_err) begin
      // An error result also empties the stack.
      out_nxt.digit = '0;
      out_nxt.last  = 1'b1;
      out_nxt.error = 1'b1;
      depth_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
    quot_r <= quot_nxt;
    base_r <= base_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[depth_r[rdc_pkg::IDX_W-1:0]] <= div_rem;
    end
    if (cmd.rd_req) begin
      rd_data_r <= stack_mem[depth_m1[rdc_pkg::IDX_W-1:0]];
    end
  end

  assign status.in_bad      = (quot_r == '0) || (base_r < rdc_pkg::BASE_WIDTH'(2));
  assign status.div_done    = div_done;
  assign status.quot_zero   = (div_quot == '0);
  assign status.full        = (depth_r == rdc_pkg::TOP_SLOT);
  assign status.stack_empty = (depth_r == '0);

  assign out_data = out_r;

endmodule

// ===== sv/rdc_ctrl.sv =====
// Controller state machine: sequences division, stack pops and result transactions.
// Depends on rdc_pkg; talks to rdc_datapath through command and status structs.
module rdc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  rdc_pkg::status_t status,
  output rdc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_READ,
    S_LOAD,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.in_bad) begin
          cmd.load_err  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_SEND;
        end else begin
          state_nxt = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.push = 1'b1;
          if (status.quot_zero) begin
            state_nxt = S_READ;
          end else if (status.full) begin
            // Digits remain but the stack is out of room.
            cmd.load_err  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_SEND;
          end else begin
            state_nxt = S_DIV_START;
          end
        end
      end
      S_READ: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_digit = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_SEND;
      end
      S_SEND: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = status.stack_empty ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/radix_digit_converter.sv =====
// Top level of the radix digit converter: controller plus datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_datapath and rdc_divider.
//
// Usage: an input transaction on in_valid/in_stall carries a value and a base.
// The block converts the value by repeated division and returns one output
// transaction per digit on out_valid/out_stall, most significant digit first,
// with last set on the final digit. A zero value or a base below two gives a
// single transaction with digit zero, last and error set.
//
// in_stall is low only while the block is idle, so one item is worked on at a
// time. Each digit costs one division in the bit-serial divider, which sets
// the rate; each digit is then popped from the stack (S_READ), loaded into the
// output register (S_LOAD) and presented (S_SEND) until the receiver takes it.
//
// Reset (rst_n low at a clock edge) returns the block to idle with an empty
// stack and no pending output. While out_stall is high the presented digit and
// out_valid hold and no further digit is popped.
module radix_digit_converter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rdc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rdc_pkg::out_t out_data
);

  rdc_pkg::cmd_t    cmd;
  rdc_pkg::status_t status;

  rdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rdc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
